/* hw/rtl/cim_pkg.sv */
// Package: shared constants, types and codes for the callback integrity monitor.
`timescale 1ns / 1ps
package cim_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int STACK_DEPTH   = 256;
    localparam int TIDX_W = $clog2(TABLE_ENTRIES);
    localparam int TCNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int SPTR_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] REG_CHECK_ENABLE  = 2'd0;
    localparam logic [1:0] REG_STRICT_MODE   = 2'd1;
    localparam logic [1:0] REG_SHADOW_ENABLE = 2'd2;

    localparam logic CMD_CALL = 1'b0;
    localparam logic CMD_RET  = 1'b1;

    localparam logic [3:0] ST_ALLOWED      = 4'd0;
    localparam logic [3:0] ST_REGISTERED   = 4'd1;
    localparam logic [3:0] ST_MISMATCH_OK  = 4'd2;
    localparam logic [3:0] ST_MISMATCH_HLT = 4'd3;
    localparam logic [3:0] ST_NULL_PASS    = 4'd4;
    localparam logic [3:0] ST_RET_OK       = 4'd5;
    localparam logic [3:0] ST_RET_MISMATCH = 4'd6;
    localparam logic [3:0] ST_RET_HALTED   = 4'd7;
    localparam logic [3:0] ST_IGNORED      = 4'd8;
    localparam logic [3:0] ST_TABLE_FULL   = 4'd9;

    // transaction handed from the front end to the back end
    typedef struct packed {
        logic        cmd;
        logic [63:0] ret_addr;
        logic [63:0] obj_addr;
        logic [63:0] obj_hash;
    } item_t;

    typedef struct packed {
        logic [3:0]        status;
        logic              stack_overflow;
        logic [7:0]        entry_violations;
        logic [15:0]       total_violations;
        logic [SPTR_W-1:0] stack_level;
    } result_t;
endpackage

/* hw/rtl/cim_queue.sv */
// Two-entry transaction queue between the front end and the back end.
`timescale 1ns / 1ps
module cim_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  cim_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_take,
    output cim_pkg::item_t out_item
);
    import cim_pkg::*;

    item_t      mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && out_take;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !out_valid)
        else $error("empty queue shows valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue push lost");
endmodule

/* hw/rtl/cim_engine.sv */
// Back end: shadow stack, sequential table search and result register.
`timescale 1ns / 1ps
module cim_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_take,
    input  cim_pkg::item_t   item,
    input  logic             check_enable,
    input  logic             strict_mode,
    input  logic             shadow_enable,
    output logic             res_valid,
    input  logic             res_stall,
    output cim_pkg::result_t res
);
    import cim_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_STK, S_SCAN, S_READ, S_EVAL, S_DONE
    } state_t;

    state_t             state_reg;
    item_t              cur_reg;
    logic [SPTR_W-1:0]  sp_reg;
    logic [15:0]        total_reg;
    logic [15:0]        shadow_reg;
    logic               halted_reg;
    logic [TCNT_W-1:0]  scan_reg;
    logic [TCNT_W-1:0]  hit_reg;
    logic [TCNT_W-1:0]  free_reg;
    logic               ovf_reg;
    logic [7:0]         ev_reg;
    logic [3:0]         status_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic [63:0] stk_ret_mem [STACK_DEPTH];
    logic [63:0] stk_obj_mem [STACK_DEPTH];
    logic [63:0] stk_ret_q;
    logic [63:0] stk_obj_q;
    logic [63:0] tab_addr_mem [TABLE_ENTRIES];
    logic [63:0] tab_hash_mem [TABLE_ENTRIES];
    logic [63:0] tab_addr_q;
    logic [63:0] tab_hash_q;
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] trusted_reg;
    logic [7:0]  viol_mem [TABLE_ENTRIES];
    logic [7:0]  viol_q;

    logic               stk_wr;
    logic [SIDX_W-1:0]  stk_widx;
    logic [SIDX_W-1:0]  stk_ridx;
    logic               tab_wr_addr;
    logic               tab_wr_hash;
    logic               viol_wr;
    logic [7:0]         viol_wdata;
    logic [7:0]         viol_inc;
    logic [TIDX_W-1:0]  tab_widx;
    logic [TIDX_W-1:0]  tab_ridx;
    logic [TIDX_W-1:0]  scan_idx;
    logic [TIDX_W-1:0]  hit_idx;
    logic [TIDX_W-1:0]  free_idx;
    logic               out_free;
    logic               scan_hit;

    assign scan_idx  = scan_reg[TIDX_W-1:0];
    assign hit_idx   = hit_reg[TIDX_W-1:0];
    assign free_idx  = free_reg[TIDX_W-1:0];
    assign out_free  = !res_valid_reg || !res_stall;
    assign item_take = (state_reg == S_IDLE) && item_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign stk_ridx = sp_reg[SIDX_W-1:0] - SIDX_W'(1);
    assign scan_hit = (tab_addr_q == cur_reg.obj_addr);
    assign viol_inc = (viol_q != 8'hFF) ? viol_q + 8'd1 : viol_q;

    // stack push happens in S_STK for calls
    assign stk_wr   = (state_reg == S_STK) && (cur_reg.cmd == CMD_CALL) && shadow_enable
                      && (sp_reg < SPTR_W'(STACK_DEPTH));
    assign stk_widx = sp_reg[SIDX_W-1:0];

    always_comb
    begin
        tab_ridx    = scan_idx;
        tab_wr_addr = 1'b0;
        tab_wr_hash = 1'b0;
        viol_wr     = 1'b0;
        viol_wdata  = '0;
        tab_widx    = hit_idx;
        if (state_reg == S_READ)
        begin
            tab_ridx = hit_idx;
        end
        if (state_reg == S_EVAL)
        begin
            if (hit_reg == TCNT_W'(TABLE_ENTRIES))
            begin
                if (free_reg != TCNT_W'(TABLE_ENTRIES))
                begin
                    tab_wr_addr = 1'b1;
                    tab_wr_hash = 1'b1;
                    viol_wr     = 1'b1;
                    tab_widx    = free_idx;
                end
            end
            else if (!trusted_reg[hit_idx] && tab_hash_q != cur_reg.obj_hash)
            begin
                viol_wr     = 1'b1;
                viol_wdata  = viol_inc;
                tab_wr_hash = !strict_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_wr)
        begin
            stk_ret_mem[stk_widx] <= cur_reg.ret_addr;
            stk_obj_mem[stk_widx] <= cur_reg.obj_addr;
        end
        stk_ret_q <= stk_ret_mem[stk_ridx];
        stk_obj_q <= stk_obj_mem[stk_ridx];
        if (tab_wr_addr)
        begin
            tab_addr_mem[tab_widx] <= cur_reg.obj_addr;
        end
        if (tab_wr_hash)
        begin
            tab_hash_mem[tab_widx] <= cur_reg.obj_hash;
        end
        if (viol_wr)
        begin
            viol_mem[tab_widx] <= viol_wdata;
        end
        tab_addr_q <= tab_addr_mem[tab_ridx];
        tab_hash_q <= tab_hash_mem[tab_ridx];
        viol_q     <= viol_mem[tab_ridx];
        if (item_take)
        begin
            cur_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            total_reg     <= '0;
            shadow_reg    <= '0;
            halted_reg    <= 1'b0;
            scan_reg      <= '0;
            hit_reg       <= '0;
            free_reg      <= '0;
            ovf_reg       <= 1'b0;
            ev_reg        <= '0;
            status_reg    <= ST_ALLOWED;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            used_reg      <= '0;
            trusted_reg   <= '0;
        end
        else
        begin
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_STK;
                    end
                end
                S_STK:
                begin
                    ovf_reg <= 1'b0;
                    ev_reg  <= '0;
                    if (halted_reg)
                    begin
                        status_reg <= ST_IGNORED;
                        state_reg  <= S_DONE;
                    end
                    else if (cur_reg.obj_addr == 64'd0)
                    begin
                        status_reg <= ST_NULL_PASS;
                        state_reg  <= S_DONE;
                    end
                    else if (cur_reg.cmd == CMD_CALL)
                    begin
                        if (shadow_enable)
                        begin
                            if (stk_wr)
                            begin
                                sp_reg <= sp_reg + SPTR_W'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        status_reg <= ST_ALLOWED;
                        scan_reg   <= '0;
                        hit_reg    <= TCNT_W'(TABLE_ENTRIES);
                        free_reg   <= TCNT_W'(TABLE_ENTRIES);
                        state_reg  <= check_enable ? S_SCAN : S_DONE;
                    end
                    else
                    begin
                        status_reg <= ST_RET_OK;
                        if (shadow_enable && sp_reg != '0)
                        begin
                            // stack read launched this cycle, compare next
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    // one entry a cycle; tab_addr_q is registered, so it holds entry scan_idx - 1
                    if (scan_reg != '0)
                    begin
                        if (used_reg[scan_idx - TIDX_W'(1)])
                        begin
                            if (hit_reg == TCNT_W'(TABLE_ENTRIES) && scan_hit)
                            begin
                                hit_reg <= scan_reg - TCNT_W'(1);
                            end
                        end
                        else if (free_reg == TCNT_W'(TABLE_ENTRIES))
                        begin
                            free_reg <= scan_reg - TCNT_W'(1);
                        end
                    end
                    if (scan_reg == TCNT_W'(TABLE_ENTRIES))
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + TCNT_W'(1);
                    end
                end
                S_READ:
                begin
                    if (cur_reg.cmd == CMD_CALL)
                    begin
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        sp_reg <= sp_reg - SPTR_W'(1);
                        if (stk_ret_q != cur_reg.ret_addr || stk_obj_q != cur_reg.obj_addr)
                        begin
                            if (shadow_reg != 16'hFFFF)
                            begin
                                shadow_reg <= shadow_reg + 16'd1;
                            end
                            if (total_reg != 16'hFFFF)
                            begin
                                total_reg <= total_reg + 16'd1;
                            end
                            if (strict_mode)
                            begin
                                halted_reg <= 1'b1;
                                status_reg <= ST_RET_HALTED;
                            end
                            else
                            begin
                                status_reg <= ST_RET_MISMATCH;
                            end
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_DONE;
                    if (hit_reg == TCNT_W'(TABLE_ENTRIES))
                    begin
                        if (free_reg == TCNT_W'(TABLE_ENTRIES))
                        begin
                            status_reg <= ST_TABLE_FULL;
                        end
                        else
                        begin
                            used_reg[free_idx]    <= 1'b1;
                            trusted_reg[free_idx] <= 1'b1;
                            status_reg            <= ST_REGISTERED;
                        end
                    end
                    else if (trusted_reg[hit_idx] || tab_hash_q == cur_reg.obj_hash)
                    begin
                        ev_reg     <= viol_q;
                        status_reg <= ST_ALLOWED;
                    end
                    else
                    begin
                        if (total_reg != 16'hFFFF)
                        begin
                            total_reg <= total_reg + 16'd1;
                        end
                        ev_reg               <= viol_inc;
                        trusted_reg[hit_idx] <= 1'b0;
                        if (strict_mode)
                        begin
                            halted_reg <= 1'b1;
                            status_reg <= ST_MISMATCH_HLT;
                        end
                        else
                        begin
                            status_reg <= ST_MISMATCH_OK;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        res_reg.status           <= status_reg;
                        res_reg.stack_overflow   <= ovf_reg;
                        res_reg.entry_violations <= ev_reg;
                        res_reg.total_violations <= total_reg;
                        res_reg.stack_level      <= sp_reg;
                        res_valid_reg            <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPTR_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(halted_reg) |-> halted_reg)
        else $error("halt cleared without reset");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> res_valid_reg && $stable(res_reg))
        else $error("stalled result changed");
endmodule

/* hw/rtl/callback_integrity_monitor.sv */
// Top level: callback integrity monitor with queue, back end and config registers.
`timescale 1ns / 1ps
// One result per transaction. A call with hash checking enabled runs a search
// that reads one table entry per cycle through the table's single read port.
// A two-entry queue takes transactions while the back end works, and the
// result register holds a finished result while the next one is built.
// No clearing pass after reset: table valid bits are flip-flops.
module callback_integrity_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [63:0] ret_addr,
    input  logic [63:0] obj_addr,
    input  logic [63:0] obj_hash,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic        stack_overflow,
    output logic [7:0]  entry_violations,
    output logic [15:0] total_violations,
    output logic [cim_pkg::SPTR_W-1:0] stack_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);
    import cim_pkg::*;

    item_t   in_item;
    item_t   q_item;
    result_t res;
    logic    q_valid;
    logic    q_take;
    logic    check_enable_reg;
    logic    strict_mode_reg;
    logic    shadow_enable_reg;

    assign in_item.cmd      = cmd;
    assign in_item.ret_addr = ret_addr;
    assign in_item.obj_addr = obj_addr;
    assign in_item.obj_hash = obj_hash;
    assign cfg_ready        = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg  <= 1'b1;
            strict_mode_reg   <= 1'b0;
            shadow_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CHECK_ENABLE:  check_enable_reg  <= cfg_data;
                REG_STRICT_MODE:   strict_mode_reg   <= cfg_data;
                REG_SHADOW_ENABLE: shadow_enable_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    cim_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_take  (q_take),
        .out_item  (q_item)
    );

    cim_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (q_valid),
        .item_take     (q_take),
        .item          (q_item),
        .check_enable  (check_enable_reg),
        .strict_mode   (strict_mode_reg),
        .shadow_enable (shadow_enable_reg),
        .res_valid     (out_valid),
        .res_stall     (out_stall),
        .res           (res)
    );

    assign status           = res.status;
    assign stack_overflow   = res.stack_overflow;
    assign entry_violations = res.entry_violations;
    assign total_violations = res.total_violations;
    assign stack_level      = res.stack_level;
endmodule

/* tb/sv/callback_integrity_monitor_tb.sv */
// Testbench for the callback integrity monitor: random and directed traffic, scoreboard check.
`timescale 1ns / 1ps
module callback_integrity_monitor_tb;
    import cim_pkg::*;

    typedef struct packed {
        logic [3:0]        status;
        logic              stack_overflow;
        logic [7:0]        entry_violations;
        logic [15:0]       total_violations;
        logic [SPTR_W-1:0] stack_level;
    } verdict_t;

    int error_count = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        begin
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            error_count++;
        end
    endtask

    // shadow-stack and hash-table predictor with its own expected-verdict queue
    class cfi_scoreboard;
        logic [63:0] sret [STACK_DEPTH];
        logic [63:0] sobj [STACK_DEPTH];
        int unsigned sp;
        logic [63:0] taddr [TABLE_ENTRIES];
        logic [63:0] thash [TABLE_ENTRIES];
        bit tused [TABLE_ENTRIES];
        bit ttrust [TABLE_ENTRIES];
        logic [7:0] tviol [TABLE_ENTRIES];
        logic [15:0] total;
        bit halted;
        bit chk_en, strict, shadow_en;
        verdict_t pending [$];

        function new();
            sp = 0; total = 0; halted = 0;
            chk_en = 1; strict = 0; shadow_en = 1;
            foreach (tused[i])
            begin
                tused[i] = 0; ttrust[i] = 0; tviol[i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic val);
            if (idx == REG_CHECK_ENABLE) chk_en = val;
            else if (idx == REG_STRICT_MODE) strict = val;
            else if (idx == REG_SHADOW_ENABLE) shadow_en = val;
        endfunction

        function logic [3:0] hash_lookup(logic [63:0] obj, logic [63:0] h, output logic [7:0] ev);
            int hit, fre;
            hit = -1; fre = -1; ev = 0;
            if (!chk_en) return ST_ALLOWED;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (tused[i]) begin if (hit < 0 && taddr[i] == obj) hit = i; end
                else if (fre < 0) fre = i;
            end
            if (hit < 0)
            begin
                if (fre < 0) return ST_TABLE_FULL;
                tused[fre] = 1; ttrust[fre] = 1; taddr[fre] = obj;
                thash[fre] = h; tviol[fre] = 0;
                return ST_REGISTERED;
            end
            if (ttrust[hit] || thash[hit] == h)
            begin
                ev = tviol[hit];
                return ST_ALLOWED;
            end
            if (total != 16'hFFFF) total++;
            if (tviol[hit] != 8'hFF) tviol[hit]++;
            ttrust[hit] = 0;
            ev = tviol[hit];
            if (strict)
            begin
                halted = 1;
                return ST_MISMATCH_HLT;
            end
            thash[hit] = h;
            return ST_MISMATCH_OK;
        endfunction

        function void note_event(logic c, logic [63:0] ra, logic [63:0] obj, logic [63:0] h);
            verdict_t v;
            v = '0;
            if (halted) v.status = ST_IGNORED;
            else if (obj == 0) v.status = ST_NULL_PASS;
            else if (c == CMD_CALL)
            begin
                if (shadow_en)
                begin
                    if (sp < STACK_DEPTH)
                    begin
                        sret[sp] = ra; sobj[sp] = obj; sp++;
                    end
                    else v.stack_overflow = 1;
                end
                v.status = hash_lookup(obj, h, v.entry_violations);
            end
            else
            begin
                v.status = ST_RET_OK;
                if (shadow_en && sp > 0)
                begin
                    sp--;
                    if (sret[sp] != ra || sobj[sp] != obj)
                    begin
                        if (total != 16'hFFFF) total++;
                        if (strict)
                        begin
                            halted = 1;
                            v.status = ST_RET_HALTED;
                        end
                        else v.status = ST_RET_MISMATCH;
                    end
                end
            end
            v.total_violations = total;
            v.stack_level = sp[SPTR_W-1:0];
            pending.push_back(v);
        endfunction

        task check_verdict(verdict_t got);
            verdict_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 64'(got), 0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) report("status", got.status, w.status);
            if (got.stack_overflow !== w.stack_overflow)
                report("stack_overflow", got.stack_overflow, w.stack_overflow);
            if (got.entry_violations !== w.entry_violations)
                report("entry_violations", got.entry_violations, w.entry_violations);
            if (got.total_violations !== w.total_violations)
                report("total_violations", got.total_violations, w.total_violations);
            if (got.stack_level !== w.stack_level)
                report("stack_level", got.stack_level, w.stack_level);
        endtask
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_stall, cmd = 0;
    logic [63:0] ret_addr = 0, obj_addr = 0, obj_hash = 0;
    logic out_valid, out_stall = 0;
    logic [3:0] status;
    logic stack_overflow;
    logic [7:0] entry_violations;
    logic [15:0] total_violations;
    logic [SPTR_W-1:0] stack_level;
    logic cfg_valid = 0, cfg_ready;
    logic [1:0] cfg_index = 0;
    logic cfg_data = 0;

    callback_integrity_monitor i_dut (.*);

    cfi_scoreboard sb = new();
    bit quiet = 0;          // no idling in the closing part
    bit hold_sink = 0;      // long receiver hold-off
    longint cycles = 0;
    logic [63:0] call_ra [$];
    logic [63:0] call_obj [$];
    logic [63:0] obj_pool [16];
    logic [63:0] hash_pool [16];

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("callback_integrity_monitor regression: fail");
            $finish;
        end
    end

    // sample results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_verdict({status, stack_overflow, entry_violations, total_violations,
                              stack_level});
    end

    // receiver stall
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_sink) out_stall <= 1;
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
            else out_stall <= 0;
        end
    end

    task automatic send(input logic c, input logic [63:0] ra, input logic [63:0] obj,
                        input logic [63:0] h);
        int n;
        begin
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 5);
                in_valid <= 0;
                repeat (n) @(negedge clk);
            end
            in_valid <= 1; cmd <= c; ret_addr <= ra; obj_addr <= obj; obj_hash <= h;
            do @(posedge clk); while (in_stall);
            sb.note_event(c, ra, obj, h);
            @(negedge clk);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 0;
            while (sb.pending.size() != 0) @(negedge clk);
            repeat (100) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        begin
            cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(idx, val);
            @(negedge clk);
            cfg_valid <= 0;
        end
    endtask

    task automatic rand_call();
        logic [63:0] ra, obj;
        int k;
        begin
            ra = {$urandom, $urandom};
            k = $urandom_range(0, 15);
            obj = obj_pool[k];
            call_ra.push_back(ra); call_obj.push_back(obj);
            send(CMD_CALL, ra, obj,
                 ($urandom_range(0, 5) == 0) ? {$urandom, $urandom} : hash_pool[k]);
        end
    endtask

    task automatic rand_ret();
        logic [63:0] ra, obj;
        begin
            if (call_ra.size() != 0)
            begin
                ra = call_ra.pop_back(); obj = call_obj.pop_back();
            end
            else
            begin
                ra = {$urandom, $urandom}; obj = obj_pool[0];
            end
            if ($urandom_range(0, 9) == 0) ra ^= 64'h1 << $urandom_range(0, 63);
            send(CMD_RET, ra, obj, {$urandom, $urandom});
        end
    endtask

    task automatic random_phase(input int count);
        int r;
        begin
            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0) send(1'($urandom_range(0, 1)), {$urandom, $urandom}, 0,
                                 {$urandom, $urandom});
                else if (r == 1) send(1'($urandom_range(0, 1)), {$urandom, $urandom},
                                      {$urandom, $urandom}, {$urandom, $urandom});
                else if (r < 11) rand_call();
                else rand_ret();
            end
        end
    endtask

    task automatic new_session();
        begin
            foreach (obj_pool[i])
            begin
                obj_pool[i] = {$urandom, $urandom} | 64'h1;
                hash_pool[i] = {$urandom, $urandom};
            end
            call_ra.delete(); call_obj.delete();
        end
    endtask

    initial
    begin
        logic [63:0] big;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        new_session();

        // directed: extremes, null, register, trusted pass, mismatches, returns
        big = '1;
        send(CMD_CALL, 0, 0, 0);
        send(CMD_RET, big, 0, big);
        send(CMD_CALL, big, big, big);
        send(CMD_CALL, 0, big, big);
        send(CMD_RET, 0, big, 0);
        send(CMD_RET, big, big, 0);
        send(CMD_RET, 1, 1, 0);
        send(CMD_CALL, 64'h5, 64'h1, 64'hAAAA);
        send(CMD_CALL, 64'h6, 64'h1, 64'hBBBB);
        send(CMD_CALL, 64'h7, 64'h1, 64'hBBBB);
        send(CMD_CALL, 64'h7, 64'h1, 64'hCCCC);
        send(CMD_RET, 64'h8, 64'h1, 0);
        send(CMD_RET, 64'h6, 64'h2, 0);
        drain();
        write_reg(REG_CHECK_ENABLE, 0);
        send(CMD_CALL, 64'h9, 64'h1, 64'hDDDD);
        drain();
        write_reg(REG_SHADOW_ENABLE, 0);
        send(CMD_CALL, 64'h9, 64'h1, 64'hDDDD);
        send(CMD_RET, 64'h0, 64'h1, 0);
        drain();
        write_reg(REG_CHECK_ENABLE, 1);
        write_reg(REG_SHADOW_ENABLE, 1);

        // fill the table past capacity
        for (int i = 0; i < TABLE_ENTRIES + 3; i++)
            send(CMD_CALL, 64'(i), 64'h1000 + 64'(i), 64'(i));
        drain();

        // fill the stack past capacity with calls kept off the table path, then return
        write_reg(REG_CHECK_ENABLE, 0);
        for (int i = 0; i < STACK_DEPTH + 4; i++)
            send(CMD_CALL, {$urandom, $urandom}, 64'h77, 0);
        for (int i = 0; i < STACK_DEPTH + 4; i++)
            send(CMD_RET, 0, 64'h77, 0);
        drain();
        write_reg(REG_CHECK_ENABLE, 1);

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_sink = 1;
                repeat (400) @(negedge clk);
                hold_sink = 0;
            end
            random_phase(12);
        join
        drain();

        // lenient random phases; reset of tables is impossible, so keep objects varied
        new_session();
        random_phase(150);
        drain();
        write_reg(REG_SHADOW_ENABLE, 0);
        new_session();
        random_phase(100);
        drain();
        write_reg(REG_SHADOW_ENABLE, 1);
        write_reg(REG_CHECK_ENABLE, 0);
        new_session();
        random_phase(100);
        drain();
        write_reg(REG_CHECK_ENABLE, 1);
        new_session();
        random_phase(100);
        drain();

        // strict mode last: the first violation halts the block for good
        write_reg(REG_STRICT_MODE, 1);
        quiet = 1;
        new_session();
        random_phase(200);
        drain();
        write_reg(REG_STRICT_MODE, 0);
        send(CMD_CALL, 1, 1, 1);
        drain();

        if (error_count == 0)
            $display("callback_integrity_monitor regression: pass");
        else
            $display("callback_integrity_monitor regression: fail");
        $finish;
    end
endmodule
